@@ rtl/core/selective_repeat_arq_sender_defines.svh @@
// Assertion macros for the selective-repeat ARQ sender.
// Used by the top level only.
`ifndef SELECTIVE_REPEAT_ARQ_SENDER_DEFINES_SVH
`define SELECTIVE_REPEAT_ARQ_SENDER_DEFINES_SVH
`ifndef SYNTHESIS
`define SRQ_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define SRQ_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`else
`define SRQ_ASSERT_IMP(lbl, clk, rst, a, c)
`define SRQ_ASSERT_NXT(lbl, clk, rst, a, c)
`endif
`endif

@@ rtl/core/srq_pkg.sv @@
// Shared constants for the selective-repeat ARQ sender.
// No dependencies.
`default_nettype none
package srq_pkg;
  localparam int SLOTS_DEF = 8;
  localparam int MAX_BYTES_DEF = 256;
  localparam logic [2:0] F_SUBMIT = 3'd0;
  localparam logic [2:0] F_NEXT   = 3'd1;
  localparam logic [2:0] F_ACK    = 3'd2;
  localparam logic [2:0] F_SCAN   = 3'd3;
  localparam logic [2:0] F_MARK   = 3'd4;
  localparam logic [2:0] F_CLEAR  = 3'd5;
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_INV  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;
  localparam logic [1:0] CFG_MAXWIN = 2'd0;
  localparam logic [1:0] CFG_TMO    = 2'd1;
  localparam logic [1:0] CFG_MISS   = 2'd2;
  localparam logic [1:0] CFG_MAXRTX = 2'd3;
endpackage
`default_nettype wire

@@ rtl/core/srq_ram.sv @@
// Generic single-port-write RAM with registered read.
// No dependencies.
`default_nettype none
module srq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/selective_repeat_arq_sender.sv @@
// Selective-repeat ARQ sender: one item at a time under a small sequencer.
// The first result word follows decode; get-next with a block first reads the payload RAM,
// and an accepted ack first clears the bitmapped slots, then slides the base over freed slots.
// A scan first walks the outstanding slots, refreshing send times of due blocks, then hands
// out each noted block in a second pass. The next input word is taken in the cycle after the
// last result word goes out. rst is synchronous: clears state, loads defaults.
`default_nettype none
`include "selective_repeat_arq_sender_defines.svh"
module selective_repeat_arq_sender #(
  parameter int SLOTS = srq_pkg::SLOTS_DEF,
  parameter int MAX_BLOCK_BYTES = srq_pkg::MAX_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  func,
  input  wire logic [15:0] seq,
  input  wire logic [8:0]  block_length,
  input  wire logic [15:0] buffer_handle,
  input  wire logic [7:0]  ack_bitmap,
  input  wire logic [31:0] now,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic             block_valid,
  output logic [15:0]      block_seq,
  output logic [8:0]       out_length,
  output logic [15:0]      out_handle,
  output logic             window_full,
  output logic             last,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int AW = $clog2(SLOTS);
  localparam int DW = 16 + 9 + 16;
  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_RD = 4'd2, S_NXT = 4'd3,
    S_ACK = 4'd4, S_SLIDE = 4'd5, S_SRD = 4'd6, S_SCMP = 4'd7, S_OUT = 4'd8,
    S_SOUT = 4'd9, S_TRD = 4'd10, S_EMIT = 4'd11;

  logic [3:0] state;
  logic [3:0] max_window;
  logic [31:0] ack_timeout;
  logic [7:0] miss_limit;
  logic [3:0] max_retransmits;
  logic [15:0] base_sequence, next_sequence, miss_count;
  logic [3:0] current_window;
  logic [SLOTS-1:0] slot_valid, slot_sent;
  logic [15:0] hits;
  logic [2:0] f;
  logic [15:0] q;
  logic [8:0] len;
  logic [15:0] hdl;
  logic [7:0] bm;
  logic [31:0] tnow;
  logic [3:0] idx, span, lim, nres;
  logic [15:0] outst;
  logic [3:0] fullw, halfw, cfgw;
  logic [AW-1:0] sl;

  // payload RAM (seq, length, handle) and send-time RAM
  logic d_we, t_we;
  logic [AW-1:0] d_wa, d_ra, t_wa, t_ra;
  logic [DW-1:0] d_wd, d_rd;
  logic [31:0] t_wd, t_rd;

  srq_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_data (
    .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
  srq_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_time (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));

  function automatic logic [3:0] clampw(input logic [3:0] w);
    logic [3:0] r;
    r = (w == 4'd0) ? 4'd1 : w;
    if (SLOTS < 15 && 32'(r) > SLOTS) r = 4'(SLOTS);
    return r;
  endfunction

  assign fullw = clampw(max_window);
  assign cfgw = clampw(cfg_data[3:0]);
  assign halfw = (fullw >> 1) > 4'd1 ? (fullw >> 1) : 4'd1;
  assign outst = next_sequence - base_sequence;
  assign sl = AW'(base_sequence + 16'(idx));
  assign in_stall = rst || (state != S_IDLE);

  logic [15:0] rel;
  assign rel = q - base_sequence;

  always_comb begin
    d_we = 1'b0; d_wa = AW'(q); d_wd = {q, len, hdl};
    t_we = 1'b0; t_wa = AW'(q); t_wd = 32'd0;
    d_ra = (state == S_DEC) ? AW'(next_sequence) : sl;
    t_ra = sl;
    case (state)
      S_DEC: begin
        if (f == srq_pkg::F_SUBMIT && len != 9'd0 && 32'(len) <= MAX_BLOCK_BYTES
            && rel < 16'(current_window)) begin
          d_we = 1'b1; t_we = 1'b1;
        end
        if (f == srq_pkg::F_MARK && rel < 16'(current_window)) begin
          t_we = 1'b1; t_wd = tnow;
        end
        if (f == srq_pkg::F_NEXT) t_wa = AW'(next_sequence);
        if (f == srq_pkg::F_NEXT && outst < 16'(current_window)
            && slot_valid[AW'(next_sequence)]) t_we = 1'b1;
      end
      S_ACK: begin
        t_wa = sl; t_we = bm[idx[2:0]];
      end
      S_SCMP: begin
        t_wa = sl; t_wd = tnow;
        t_we = slot_valid[sl] && slot_sent[sl] && (tnow - t_rd) >= ack_timeout;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      max_window <= 4'd8; ack_timeout <= 32'd1000; miss_limit <= 8'd3;
      max_retransmits <= 4'd8; current_window <= clampw(4'd8);
      base_sequence <= '0; next_sequence <= '0; miss_count <= '0;
      slot_valid <= '0; slot_sent <= '0; out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          srq_pkg::CFG_MAXWIN: begin
            max_window <= cfg_data[3:0]; current_window <= cfgw;
          end
          srq_pkg::CFG_TMO: ack_timeout <= cfg_data;
          srq_pkg::CFG_MISS: miss_limit <= cfg_data[7:0];
          default: max_retransmits <= cfg_data[3:0];
        endcase
      end
      case (state)
        S_IDLE: if (in_valid) begin
          f <= func; q <= seq; len <= block_length; hdl <= buffer_handle;
          bm <= ack_bitmap; tnow <= now; state <= S_DEC; idx <= '0; nres <= '0;
        end
        S_DEC: begin
          status <= srq_pkg::ST_OK; block_valid <= 1'b0; block_seq <= '0;
          out_length <= '0; out_handle <= '0; last <= 1'b1; state <= S_OUT;
          case (f)
            srq_pkg::F_SUBMIT: begin
              if (len == 9'd0 || 32'(len) > MAX_BLOCK_BYTES) status <= srq_pkg::ST_INV;
              else if (rel >= 16'(current_window)) status <= srq_pkg::ST_FULL;
              else begin
                slot_valid[AW'(q)] <= 1'b1; slot_sent[AW'(q)] <= 1'b0;
              end
            end
            srq_pkg::F_NEXT: begin
              if (outst >= 16'(current_window) || !slot_valid[AW'(next_sequence)])
                status <= srq_pkg::ST_NONE;
              else begin
                slot_sent[AW'(next_sequence)] <= 1'b1;
                state <= S_RD;
              end
            end
            srq_pkg::F_ACK: if (q == base_sequence) begin
              miss_count <= '0; current_window <= fullw; state <= S_ACK;
            end
            srq_pkg::F_SCAN: begin
              span <= (outst > 16'(current_window)) ? current_window : outst[3:0];
              lim <= (max_retransmits > 4'd8) ? 4'd8 : max_retransmits;
              hits <= '0;
              state <= S_TRD;
            end
            srq_pkg::F_MARK: if (rel < 16'(current_window)) slot_sent[AW'(q)] <= 1'b1;
            srq_pkg::F_CLEAR: begin
              base_sequence <= '0; next_sequence <= '0; miss_count <= '0;
              slot_valid <= '0; slot_sent <= '0; current_window <= fullw;
            end
            default: status <= srq_pkg::ST_INV;
          endcase
        end
        S_RD: begin
          block_valid <= 1'b1;
          {block_seq, out_length, out_handle} <= d_rd;
          next_sequence <= next_sequence + 16'd1;
          state <= S_OUT;
        end
        S_ACK: begin
          if (bm[idx[2:0]]) begin
            slot_valid[sl] <= 1'b0; slot_sent[sl] <= 1'b0;
          end
          if (idx == 4'd7) begin idx <= '0; state <= S_SLIDE; end
          else idx <= idx + 4'd1;
        end
        S_SLIDE: begin
          if (idx == 4'd8 || outst == 16'd0 || slot_valid[AW'(base_sequence)])
            state <= S_OUT;
          else begin
            base_sequence <= base_sequence + 16'd1; idx <= idx + 4'd1;
          end
        end
        // scan, first pass: refresh send times and miss count, note due slots
        S_TRD: begin
          if (idx >= span || nres >= lim) begin
            idx <= '0;
            state <= (nres == 4'd0) ? S_OUT : S_SOUT;
          end else state <= S_SRD;
        end
        S_SRD: state <= S_SCMP;
        S_SCMP: begin
          if (slot_valid[sl] && slot_sent[sl] && (tnow - t_rd) >= ack_timeout) begin
            hits[idx] <= 1'b1;
            nres <= nres + 4'd1;
            if (miss_count != 16'hFFFF) begin
              miss_count <= miss_count + 16'd1;
              if (miss_count + 16'd1 >= 16'(miss_limit)) current_window <= halfw;
            end else if (miss_count >= 16'(miss_limit)) current_window <= halfw;
          end
          idx <= idx + 4'd1; state <= S_TRD;
        end
        // second pass: hand out noted slots; window state is final by now
        S_SOUT: begin
          if (hits[idx]) state <= S_EMIT;
          else idx <= idx + 4'd1;
        end
        S_EMIT: begin
          block_valid <= 1'b1;
          {block_seq, out_length, out_handle} <= d_rd;
          hits[idx] <= 1'b0;
          last <= (hits & ~(16'd1 << idx)) == 16'd0;
          idx <= idx + 4'd1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            window_full <= outst >= 16'(current_window); out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            if (f == srq_pkg::F_SCAN && !last) state <= S_SOUT;
            else state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SRQ_ASSERT_IMP(a_no_out_idle, clk, rst, state == S_IDLE, !out_valid)
  `SRQ_ASSERT_IMP(a_win_range, clk, rst, 1'b1, current_window != 4'd0)
  `SRQ_ASSERT_NXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status))
endmodule
`default_nettype wire

@@ tb/sv/tb_selective_repeat_arq_sender.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the selective-repeat ARQ sender.
// Depends on srq_pkg and the selective_repeat_arq_sender top level.
module tb_selective_repeat_arq_sender;

  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [1:0]  status;
    logic        bv;
    logic [15:0] bseq;
    logic [8:0]  blen;
    logic [15:0] bhdl;
    logic        wf;
    logic        lst;
  } arq_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] func = '0;
  logic [15:0] seq = '0;
  logic [8:0] block_length = '0;
  logic [15:0] buffer_handle = '0;
  logic [7:0] ack_bitmap = '0;
  logic [31:0] now = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic block_valid;
  logic [15:0] block_seq;
  logic [8:0] out_length;
  logic [15:0] out_handle;
  logic window_full;
  logic last;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  selective_repeat_arq_sender u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .func(func), .seq(seq),
    .block_length(block_length), .buffer_handle(buffer_handle), .ack_bitmap(ack_bitmap),
    .now(now), .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .block_valid(block_valid), .block_seq(block_seq), .out_length(out_length),
    .out_handle(out_handle), .window_full(window_full), .last(last), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted sender state
  logic [3:0]  reg_max_win = 4'd8;
  logic [31:0] reg_timeout = 32'd1000;
  logic [7:0]  reg_miss_lim = 8'd3;
  logic [3:0]  reg_max_rtx = 4'd8;
  logic [15:0] win_base, win_next, miss_cnt;
  int unsigned cur_win;
  logic        sl_valid[8], sl_sent[8];
  logic [15:0] sl_seq[8], sl_hdl[8];
  logic [8:0]  sl_len[8];
  logic [31:0] sl_time[8];

  arq_result_t pending_results[$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int blocks_seen = 0;
  int in_pct = 0;
  int out_pct = 0;
  bit hold_go = 0;
  int unsigned cycles = 0;

  function automatic int unsigned full_win();
    int unsigned w;
    w = 32'(reg_max_win);
    if (w == 0) w = 1;
    if (w > 8) w = 8;
    return w;
  endfunction

  function automatic int unsigned in_flight();
    logic [15:0] d;
    d = win_next - win_base;
    return 32'(d);
  endfunction

  task automatic clear_arq_state();
    win_base = '0;
    win_next = '0;
    miss_cnt = '0;
    for (int i = 0; i < 8; i++) begin
      sl_valid[i] = 0; sl_sent[i] = 0; sl_seq[i] = '0;
      sl_len[i] = '0; sl_hdl[i] = '0; sl_time[i] = '0;
    end
    cur_win = full_win();
  endtask

  function automatic arq_result_t mk_result(logic [1:0] st, bit has, int s);
    arq_result_t r;
    r = '0;
    r.status = st;
    r.bv = has;
    if (has) begin
      r.bseq = sl_seq[s]; r.blen = sl_len[s]; r.bhdl = sl_hdl[s];
    end
    return r;
  endfunction

  task automatic predict_word(logic [2:0] f, logic [15:0] sq, logic [8:0] len,
                              logic [15:0] hd, logic [7:0] bm, logic [31:0] tnow);
    arq_result_t res[$];
    logic [15:0] off;
    logic [31:0] age;
    int s;
    int unsigned lim, span, half;
    bit wf;
    off = sq - win_base;
    case (f)
      srq_pkg::F_SUBMIT: begin
        if (len == 0 || len > 256) res.push_back(mk_result(srq_pkg::ST_INV, 0, 0));
        else if (off >= cur_win) res.push_back(mk_result(srq_pkg::ST_FULL, 0, 0));
        else begin
          s = int'(sq[2:0]);
          sl_valid[s] = 1; sl_sent[s] = 0; sl_seq[s] = sq;
          sl_len[s] = len; sl_hdl[s] = hd; sl_time[s] = '0;
          res.push_back(mk_result(srq_pkg::ST_OK, 0, 0));
        end
      end
      srq_pkg::F_NEXT: begin
        s = int'(win_next[2:0]);
        if (in_flight() >= cur_win || !sl_valid[s])
          res.push_back(mk_result(srq_pkg::ST_NONE, 0, 0));
        else begin
          res.push_back(mk_result(srq_pkg::ST_OK, 1, s));
          sl_time[s] = '0; sl_sent[s] = 1;
          win_next = win_next + 16'd1;
        end
      end
      srq_pkg::F_ACK: begin
        if (sq == win_base) begin
          miss_cnt = '0;
          cur_win = full_win();
          for (int i = 0; i < 8; i++) begin
            if (bm[i]) begin
              s = int'(3'(win_base + 16'(i)));
              sl_valid[s] = 0; sl_sent[s] = 0; sl_time[s] = '0;
            end
          end
          for (int i = 0; i < 8; i++) begin
            if (in_flight() == 0) break;
            if (sl_valid[int'(win_base[2:0])]) break;
            win_base = win_base + 16'd1;
          end
        end
        res.push_back(mk_result(srq_pkg::ST_OK, 0, 0));
      end
      srq_pkg::F_SCAN: begin
        lim = reg_max_rtx > 8 ? 8 : 32'(reg_max_rtx);
        span = in_flight() > cur_win ? cur_win : in_flight();
        for (int unsigned i = 0; i < span && res.size() < lim; i++) begin
          s = int'(3'(win_base + 16'(i)));
          if (!sl_valid[s] || !sl_sent[s]) continue;
          age = tnow - sl_time[s];
          if (age >= reg_timeout) begin
            res.push_back(mk_result(srq_pkg::ST_OK, 1, s));
            sl_time[s] = tnow;
            if (miss_cnt != 16'hFFFF) miss_cnt = miss_cnt + 16'd1;
            if (miss_cnt >= 16'(reg_miss_lim)) begin
              half = full_win() / 2;
              cur_win = half > 1 ? half : 1;
            end
          end
        end
        if (res.size() == 0) res.push_back(mk_result(srq_pkg::ST_OK, 0, 0));
      end
      srq_pkg::F_MARK: begin
        if (off < cur_win) begin
          s = int'(sq[2:0]);
          sl_time[s] = tnow; sl_sent[s] = 1;
        end
        res.push_back(mk_result(srq_pkg::ST_OK, 0, 0));
      end
      srq_pkg::F_CLEAR: begin
        clear_arq_state();
        res.push_back(mk_result(srq_pkg::ST_OK, 0, 0));
      end
      default: res.push_back(mk_result(srq_pkg::ST_INV, 0, 0));
    endcase
    wf = in_flight() >= cur_win;
    foreach (res[k]) begin
      res[k].wf = wf;
      res[k].lst = (k == res.size() - 1);
      pending_results.push_back(res[k]);
    end
  endtask

  // one word on the input channel; valid stays high on return
  task automatic send_word(logic [2:0] f, logic [15:0] sq, logic [8:0] len,
                           logic [15:0] hd, logic [7:0] bm, logic [31:0] tnow);
    while ($urandom_range(99) < in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f; seq <= sq; block_length <= len;
    buffer_handle <= hd; ack_bitmap <= bm; now <= tnow;
    do @(posedge clk); while (in_stall);
    predict_word(f, sq, len, hd, bm, tnow);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    wait_drained();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      srq_pkg::CFG_MAXWIN: begin reg_max_win = val[3:0]; cur_win = full_win(); end
      srq_pkg::CFG_TMO:    reg_timeout = val;
      srq_pkg::CFG_MISS:   reg_miss_lim = val[7:0];
      default:             reg_max_rtx = val[3:0];
    endcase
    @(posedge clk);
  endtask

  task automatic random_word();
    int r;
    logic [8:0] len;
    r = $urandom_range(99);
    len = 9'($urandom_range(1, 256));
    if ($urandom_range(19) == 0) len = $urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(257, 511));
    if (r < 30)
      send_word(srq_pkg::F_SUBMIT, win_base + 16'($urandom_range(0, cur_win)), len,
                16'($urandom), 8'($urandom), $urandom);
    else if (r < 48)
      send_word(srq_pkg::F_NEXT, 16'($urandom), len, 16'($urandom), 8'($urandom), $urandom);
    else if (r < 60)
      send_word(srq_pkg::F_MARK, win_base + 16'($urandom_range(0, 8)), len, 16'($urandom),
                8'($urandom), 32'($urandom_range(0, 2000)));
    else if (r < 75)
      send_word(srq_pkg::F_SCAN, 16'($urandom), len, 16'($urandom), 8'($urandom),
                $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 4000)));
    else if (r < 92)
      send_word(srq_pkg::F_ACK, $urandom_range(0, 6) == 0 ? 16'($urandom) : win_base, len,
                16'($urandom), 8'($urandom), $urandom);
    else if (r < 94)
      send_word(srq_pkg::F_CLEAR, 16'($urandom), len, 16'($urandom), 8'($urandom), $urandom);
    else
      send_word(3'($urandom_range(0, 7)), 16'($urandom), 9'($urandom), 16'($urandom),
                8'($urandom), $urandom);
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      arq_result_t act;
      arq_result_t exp_r;
      act = '{status, block_valid, block_seq, out_length, out_handle, window_full, last};
      results_seen++;
      if (block_valid) blocks_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word %p", $realtime, act);
      end else begin
        exp_r = pending_results.pop_front();
        if (act != exp_r) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $realtime, exp_r, act);
        end
      end
    end
    out_stall <= hold_go || ($urandom_range(99) < out_pct);
  end

  // long receiver hold-off
  always begin
    wait (hold_go);
    repeat (300) @(posedge clk);
    hold_go = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("selective_repeat_arq_sender test failed");
      $finish;
    end
  end

  task automatic test_submit_cases();
    send_word(srq_pkg::F_SUBMIT, 16'd0, 9'd0, 16'hFFFF, 8'h00, 32'd0);
    send_word(srq_pkg::F_SUBMIT, 16'd0, 9'd257, 16'h0000, 8'h00, 32'd0);
    send_word(srq_pkg::F_SUBMIT, 16'd0, 9'd256, 16'hFFFF, 8'h00, 32'd0);
    send_word(srq_pkg::F_SUBMIT, 16'd1, 9'd1, 16'h0000, 8'h00, 32'd0);
    send_word(srq_pkg::F_SUBMIT, 16'd8, 9'd5, 16'h1234, 8'h00, 32'd0);
    send_word(srq_pkg::F_SUBMIT, 16'hFFFF, 9'd9, 16'h5555, 8'h00, 32'd0);
    send_word(srq_pkg::F_SUBMIT, 16'd1, 9'd100, 16'hAAAA, 8'h00, 32'd0);
  endtask

  task automatic test_send_and_retransmit();
    send_word(srq_pkg::F_NEXT, 16'd0, 9'd0, 16'd0, 8'h00, 32'd0);
    send_word(srq_pkg::F_NEXT, 16'd0, 9'd0, 16'd0, 8'h00, 32'd0);
    send_word(srq_pkg::F_NEXT, 16'd0, 9'd0, 16'd0, 8'h00, 32'd0);
    send_word(srq_pkg::F_MARK, 16'd9, 9'd0, 16'd0, 8'h00, 32'd5);
    send_word(srq_pkg::F_MARK, 16'd0, 9'd0, 16'd0, 8'h00, 32'd10);
    send_word(srq_pkg::F_MARK, 16'd5, 9'd0, 16'd0, 8'h00, 32'd10);
    send_word(srq_pkg::F_SCAN, 16'd0, 9'd0, 16'd0, 8'h00, 32'd20);
    send_word(srq_pkg::F_SCAN, 16'd0, 9'd0, 16'd0, 8'h00, 32'hFFFF_FFFF);
    send_word(srq_pkg::F_ACK, 16'd3, 9'd0, 16'd0, 8'hFF, 32'd0);
    send_word(srq_pkg::F_ACK, 16'd0, 9'd0, 16'd0, 8'h02, 32'd0);
    send_word(srq_pkg::F_ACK, 16'd0, 9'd0, 16'd0, 8'hFF, 32'd0);
    send_word(3'd6, 16'hFFFF, 9'h1FF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    send_word(3'd7, 16'd0, 9'd0, 16'd0, 8'h00, 32'd0);
    send_word(srq_pkg::F_CLEAR, 16'd0, 9'd0, 16'd0, 8'h00, 32'd0);
  endtask

  task automatic test_config_extremes();
    write_reg(srq_pkg::CFG_MAXWIN, 32'd0);
    write_reg(srq_pkg::CFG_TMO, 32'd0);
    write_reg(srq_pkg::CFG_MISS, 32'd0);
    write_reg(srq_pkg::CFG_MAXRTX, 32'd0);
    send_word(srq_pkg::F_SUBMIT, 16'd0, 9'd7, 16'd7, 8'h00, 32'd0);
    send_word(srq_pkg::F_NEXT, 16'd0, 9'd0, 16'd0, 8'h00, 32'd0);
    send_word(srq_pkg::F_SCAN, 16'd0, 9'd0, 16'd0, 8'h00, 32'd0);
    write_reg(srq_pkg::CFG_MAXRTX, 32'd15);
    send_word(srq_pkg::F_SCAN, 16'd0, 9'd0, 16'd0, 8'h00, 32'd0);
    write_reg(srq_pkg::CFG_MAXWIN, 32'd15);
    write_reg(srq_pkg::CFG_TMO, 32'hFFFF_FFFF);
    write_reg(srq_pkg::CFG_MISS, 32'd255);
    send_word(srq_pkg::F_SCAN, 16'd0, 9'd0, 16'd0, 8'h00, 32'd0);
    send_word(srq_pkg::F_CLEAR, 16'd0, 9'd0, 16'd0, 8'h00, 32'd0);
  endtask

  task automatic test_random_phase(int ip, int op, int count,
                                   logic [3:0] win, logic [31:0] tmo, logic [7:0] ml,
                                   logic [3:0] rtx);
    write_reg(srq_pkg::CFG_MAXWIN, 32'(win));
    write_reg(srq_pkg::CFG_TMO, tmo);
    write_reg(srq_pkg::CFG_MISS, 32'(ml));
    write_reg(srq_pkg::CFG_MAXRTX, 32'(rtx));
    in_pct = ip;
    out_pct = op;
    repeat (count) random_word();
  endtask

  task automatic test_backpressure();
    out_pct = 0;
    in_pct = 0;
    hold_go = 1;
    repeat (12) random_word();
    wait_drained();
  endtask

  initial begin
    clear_arq_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_submit_cases();
    test_send_and_retransmit();
    wait_drained();
    test_config_extremes();
    test_random_phase(0, 0, 48, 4'd8, 32'd500, 8'd3, 4'd8);
    test_random_phase(63, 0, 48, 4'd1, 32'd0, 8'd1, 4'd2);
    test_random_phase(0, 63, 48, 4'd5, 32'd1500, 8'd255, 4'd15);
    test_random_phase(18, 18, 48, 4'd15, 32'd200, 8'd0, 4'd3);
    test_backpressure();
    wait_drained();
    $display("Covered %0d input words and %0d result words (%0d carrying blocks)",
             words_sent, results_seen, blocks_seen);
    $display("across window, timeout, miss and retransmit settings with random stalls.");
    if (errors == 0) begin
      $display("selective_repeat_arq_sender test passed");
    end else begin
      $display("selective_repeat_arq_sender test failed");
    end
    $finish;
  end
endmodule
